[rtl/core/smsrng_pkg.sv]
// Shared types, constants and helpers of the shuffled minimal standard generator.
package smsrng_pkg;

   localparam int VALUE_W      = 31;
   localparam int MULT_W       = 15;
   localparam int PROD_W       = VALUE_W + MULT_W;
   localparam int WARMUP_STEPS = 8;

   localparam logic [MULT_W-1:0]  LCG_MULT = 15'd16807;
   localparam logic [VALUE_W-1:0] LCG_MOD  = 31'h7FFF_FFFF;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEED_MUL,
      ST_SEED_RED,
      ST_DRAW_MUL,
      ST_DRAW_RED,
      ST_DRAW_DIV,
      ST_DRAW_WRITE
   } state_type;

   typedef struct packed {
      logic seed_load;
      logic seed_from_req;
      logic mul_en;
      logic seed_red;
      logic draw_red;
      logic rd_en;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic last_zero;
      logic pos_zero;
      logic div_done;
   } status_type;

   // p mod (2^31 - 1) for p = x * 16807 with x below the modulus
   function automatic logic [VALUE_W-1:0] mod_reduce(input logic [PROD_W-1:0] p);
      logic [VALUE_W:0] sum;
      sum = {1'b0, p[VALUE_W-1:0]} + (VALUE_W+1)'(p[PROD_W-1:VALUE_W]);
      if (sum >= {1'b0, LCG_MOD}) begin
         sum = sum - {1'b0, LCG_MOD};
      end
      return sum[VALUE_W-1:0];
   endfunction

endpackage

[rtl/core/smsrng_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module smsrng_ram #(
   parameter int WIDTH = 31,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/smsrng_ctrl.sv]
// Sequencer for reseed, draw and result hand-off.
module smsrng_ctrl
   import smsrng_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_type,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type status_i,
   output cmd_type    cmd_o
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_type || status_i.last_zero) begin
                  state_in = ST_SEED_MUL;
               end else begin
                  state_in = ST_DRAW_RED;
               end
            end
         end
         ST_SEED_MUL: state_in = ST_SEED_RED;
         ST_SEED_RED: begin
            state_in = status_i.pos_zero ? ST_DRAW_MUL : ST_SEED_MUL;
         end
         ST_DRAW_MUL: state_in = ST_DRAW_RED;
         ST_DRAW_RED: begin
            state_in = status_i.div_done ? ST_DRAW_WRITE : ST_DRAW_DIV;
         end
         ST_DRAW_DIV: begin
            if (status_i.div_done) begin
               state_in = ST_DRAW_WRITE;
            end
         end
         ST_DRAW_WRITE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd_o = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd_o.mul_en = 1'b1;
            if (req_valid && (req_type || status_i.last_zero)) begin
               cmd_o.seed_load     = 1'b1;
               cmd_o.seed_from_req = req_type;
            end
         end
         ST_SEED_MUL: cmd_o.mul_en   = 1'b1;
         ST_SEED_RED: cmd_o.seed_red = 1'b1;
         ST_DRAW_MUL: cmd_o.mul_en   = 1'b1;
         ST_DRAW_RED: begin
            cmd_o.draw_red = 1'b1;
            cmd_o.rd_en    = status_i.div_done;
         end
         ST_DRAW_DIV: cmd_o.rd_en = status_i.div_done;
         ST_DRAW_WRITE: cmd_o.out_load = !rsp_valid_ff || !rsp_stall;
         default: cmd_o = '0;
      endcase
   end

   assign rsp_valid_in = cmd_o.out_load | (rsp_valid_ff & rsp_stall);
   assign req_stall    = (state_ff != ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;

`ifndef NO_ASSERTIONS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff != ST_IDLE)
      else $error("block idle right after accepting a beat");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd_o.out_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result register overwritten while stalled");

   a_rsp_from_write: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DRAW_WRITE)
      else $error("result beat raised outside the write step");

   a_seed_to_draw: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SEED_RED && status_i.pos_zero |=> state_ff == ST_DRAW_MUL)
      else $error("table fill did not hand over to the draw");
`endif

endmodule

[rtl/core/smsrng_dp.sv]
// Generator, shuffle table, index divider and result register.
module smsrng_dp
   import smsrng_pkg::*;
#(
   parameter int TABLE_DEPTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [VALUE_W-1:0] req_seed_value,
   input  cmd_type            cmd_i,
   output status_type         status_o,
   output logic [VALUE_W-1:0] rsp_random_value
);

   localparam int IDX_W    = $clog2(TABLE_DEPTH);
   localparam int QW       = IDX_W + 1;
   localparam int POS_W    = $clog2(TABLE_DEPTH + WARMUP_STEPS);
   localparam int POS_INIT = TABLE_DEPTH + WARMUP_STEPS - 1;
   localparam int MW       = VALUE_W + QW;

   localparam logic [VALUE_W-1:0] PICK_DIV =
      VALUE_W'(64'd1 + (64'(LCG_MOD) - 64'd1) / 64'(TABLE_DEPTH));
   localparam logic [QW-1:0] PICK_RECIP =
      QW'((64'd1 << VALUE_W) / 64'(PICK_DIV));

   logic [VALUE_W-1:0] x_ff, x_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [VALUE_W-1:0] last_ff, last_in;
   logic [VALUE_W-1:0] out_ff, out_in;
   logic [MW-1:0]      m1_ff, m1_in;
   logic [MW-1:0]      t_ff, t_in;
   logic [QW-1:0]      q0_ff, q0_in;
   logic               s1_ff, s1_in;
   logic               s2_ff, s2_in;

   logic [VALUE_W-1:0] reduced;
   logic [VALUE_W-1:0] seed_init;
   logic               pos_in_table;
   logic               last_load;
   logic [QW-1:0]      q0_cur;
   logic [QW-1:0]      q_fix;
   logic [IDX_W-1:0]   idx;
   logic               ram_we;
   logic [IDX_W-1:0]   ram_waddr;
   logic [VALUE_W-1:0] ram_wdata;
   logic [VALUE_W-1:0] ram_rdata;

   assign reduced = mod_reduce(prod_ff);

   assign seed_init = (cmd_i.seed_from_req && (req_seed_value != '0)
                       && (req_seed_value != LCG_MOD)) ? req_seed_value : VALUE_W'(1);

   assign pos_in_table = (pos_ff < POS_W'(TABLE_DEPTH));
   assign last_load    = (cmd_i.seed_red && (pos_ff == '0)) || cmd_i.out_load;

   always_comb begin
      x_in = x_ff;
      if (cmd_i.seed_load) begin
         x_in = seed_init;
      end else if (cmd_i.seed_red || cmd_i.draw_red) begin
         x_in = reduced;
      end
   end

   assign prod_in = cmd_i.mul_en ? (PROD_W'(x_ff) * PROD_W'(LCG_MULT)) : prod_ff;

   always_comb begin
      pos_in = pos_ff;
      if (cmd_i.seed_load) begin
         pos_in = POS_W'(POS_INIT);
      end else if (cmd_i.seed_red) begin
         pos_in = pos_ff - POS_W'(1);
      end
   end

   always_comb begin
      last_in = last_ff;
      if (cmd_i.out_load) begin
         last_in = ram_rdata;
      end else if (last_load) begin
         last_in = reduced;
      end
   end

   assign out_in = cmd_i.out_load ? ram_rdata : out_ff;

   // index = last / PICK_DIV: reciprocal estimate, then one-step correction
   assign m1_in  = last_load ? (MW'(last_in) * MW'(PICK_RECIP)) : m1_ff;
   assign q0_cur = m1_ff[VALUE_W +: QW];
   assign q0_in  = s1_ff ? q0_cur : q0_ff;
   assign t_in   = s1_ff ? (MW'(q0_cur + QW'(1)) * MW'(PICK_DIV)) : t_ff;
   assign s1_in  = last_load;
   assign s2_in  = last_load ? 1'b0 : (s1_ff | s2_ff);

   assign q_fix = (MW'(last_ff) >= t_ff) ? (q0_ff + QW'(1)) : q0_ff;
   assign idx   = (q_fix >= QW'(TABLE_DEPTH)) ? IDX_W'(TABLE_DEPTH - 1) : q_fix[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff    <= VALUE_W'(1);
         last_ff <= '0;
         s1_ff   <= 1'b0;
         s2_ff   <= 1'b0;
      end else begin
         x_ff    <= x_in;
         last_ff <= last_in;
         s1_ff   <= s1_in;
         s2_ff   <= s2_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      pos_ff  <= pos_in;
      out_ff  <= out_in;
      m1_ff   <= m1_in;
      t_ff    <= t_in;
      q0_ff   <= q0_in;
   end

   assign ram_we    = (cmd_i.seed_red && pos_in_table) || cmd_i.out_load;
   assign ram_waddr = cmd_i.seed_red ? pos_ff[IDX_W-1:0] : idx;
   assign ram_wdata = cmd_i.seed_red ? reduced : x_ff;

   smsrng_ram #(
      .WIDTH(VALUE_W),
      .DEPTH(TABLE_DEPTH)
   ) u_table (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_en  (cmd_i.rd_en),
      .rd_addr(idx),
      .rd_data(ram_rdata)
   );

   assign status_o.last_zero = (last_ff == '0);
   assign status_o.pos_zero  = (pos_ff == '0);
   assign status_o.div_done  = s2_ff;

   assign rsp_random_value = out_ff;

endmodule

[rtl/core/shuffled_minimal_standard_rng_core.sv]
// Draw: the generator reduce step issues the shuffle-table read, then the result is
// written (the index divider runs in the background); no new request is taken
// before that write. Reseed: each generator step is a multiply, then a modular
// reduce. A draw before any seed runs a seed-1 reseed first.
// Reset clears the sequencer and marks the generator unseeded; the table is not
// cleared and is always filled by a reseed before it is read.
module shuffled_minimal_standard_rng_core
   import smsrng_pkg::*;
#(
   parameter int TABLE_DEPTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_type,
   input  logic [VALUE_W-1:0] req_seed_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [VALUE_W-1:0] rsp_random_value
);

   cmd_type    cmd;
   status_type status;

   smsrng_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_type (req_type),
      .req_stall(req_stall),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .status_i (status),
      .cmd_o    (cmd)
   );

   smsrng_dp #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_seed_value  (req_seed_value),
      .cmd_i           (cmd),
      .status_o        (status),
      .rsp_random_value(rsp_random_value)
   );

endmodule
